// ===== src/rfo_pkg.sv =====
// Package for the ring FIFO with overwrite: sizes, opcode enum and the
// structs passed between the control and the top level. No dependencies.
package rfo_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned ElemW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ElemW-1:0] elem_t;

  typedef enum logic [1:0] {
    OpWrite     = 2'd0,
    OpOverwrite = 2'd1,
    OpPeek      = 2'd2,
    OpRead      = 2'd3
  } op_e;

  // Memory port request issued when an item is accepted.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    elem_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // Registered result status; data_sel picks the RAM read data.
  typedef struct packed {
    logic success;
    logic evicted;
    logic data_sel;
    cnt_t count;
  } res_t;

endpackage

// ===== src/rfo_ram.sv =====
// Generic single-write, single-read synchronous RAM, read-first.
// Read data is registered and held until the next read enable. No dependencies.
module rfo_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Same-address write and read in one cycle returns the old entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rfo_ctrl.sv =====
// Head/count control and result register of the ring FIFO.
// Depends on rfo_pkg.
module rfo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  rfo_pkg::op_e      op_i,
  input  rfo_pkg::elem_t    data_i,
  input  logic              out_take_i,
  output rfo_pkg::mem_req_t mem_req_o,
  output rfo_pkg::res_t     res_o,
  output logic              out_valid_o
);
  import rfo_pkg::*;

  addr_t head_q, head_d;
  cnt_t  count_q, count_d;
  res_t  res_q, res_d;
  logic  valid_q, valid_d;
  logic  full, empty;
  addr_t tail;

  assign full  = (count_q == cnt_t'(Depth));
  assign empty = (count_q == '0);
  assign tail  = head_q + count_q[AddrW-1:0];

  always_comb begin
    head_d            = head_q;
    count_d           = count_q;
    res_d             = res_q;
    mem_req_o.we      = 1'b0;
    mem_req_o.waddr   = tail;
    mem_req_o.wdata   = data_i;
    mem_req_o.re      = 1'b0;
    mem_req_o.raddr   = head_q;
    if (accept_i) begin
      res_d = '0;
      case (op_i)
        OpWrite, OpOverwrite: begin
          if (!full) begin
            mem_req_o.we  = 1'b1;
            count_d       = count_q + cnt_t'(1);
            res_d.success = 1'b1;
          end else if (op_i == OpOverwrite) begin
            // tail equals head when full: read-first RAM returns the victim
            mem_req_o.we   = 1'b1;
            mem_req_o.re   = 1'b1;
            head_d         = head_q + addr_t'(1);
            res_d.evicted  = 1'b1;
            res_d.data_sel = 1'b1;
          end
        end
        OpPeek, OpRead: begin
          if (!empty) begin
            mem_req_o.re   = 1'b1;
            res_d.success  = 1'b1;
            res_d.data_sel = 1'b1;
            if (op_i == OpRead) begin
              head_d  = head_q + addr_t'(1);
              count_d = count_q - cnt_t'(1);
            end
          end
        end
        default: ;
      endcase
      res_d.count = count_d;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign out_valid_o = valid_q;

endmodule

// ===== src/ring_fifo_with_overwrite_unit.sv =====
// Top level of the ring FIFO with overwrite: control plus element RAM.
// Depends on rfo_pkg, rfo_ctrl and rfo_ram.
//
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid_i, in_ready_o, opcode_i, data_in_i | into block
// out     | out_valid_o, out_ready_i, success_o,        | out of block
//         | evicted_o, data_out_o, fill_count_o         |
//
// An item is accepted at a clock edge, and its result is shown from the
// cycle after on. One item per cycle is sustained while the output is
// taken each cycle; the registered read of the single RAM read port
// sets when the result appears.
// Reset clears head, count and output valid; the RAM is not cleared.
// A stalled output holds its item and blocks input until taken; the RAM
// read register is enabled only on accept, so data_out stays stable.
module ring_fifo_with_overwrite_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        success_o,
  output logic        evicted_o,
  output logic [31:0] data_out_o,
  output logic [4:0]  fill_count_o
);
  import rfo_pkg::*;

  logic     accept;
  logic     out_take;
  mem_req_t mem_req;
  res_t     res;
  elem_t    rdata;
  logic     out_valid;

  // Output register frees up when taken, so input may enter the same cycle.
  assign in_ready_o = !out_valid || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_take   = out_valid && out_ready_i;

  rfo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_e'(opcode_i)),
    .data_i      (elem_t'(data_in_i)),
    .out_take_i  (out_take),
    .mem_req_o   (mem_req),
    .res_o       (res),
    .out_valid_o (out_valid)
  );

  rfo_ram #(
    .Width (ElemW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o  = out_valid;
  assign success_o    = res.success;
  assign evicted_o    = res.evicted;
  assign data_out_o   = res.data_sel ? 32'(rdata) : 32'd0;
  assign fill_count_o = 5'(res.count);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o <= 5'(Depth)))
    else $error("fill count above depth");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> (!success_o && fill_count_o == 5'(Depth)))
    else $error("eviction reported without a full FIFO");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !accept) |=> !out_valid_o)
    else $error("result repeated after being taken");

  a_no_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !success_o && !evicted_o) |-> (data_out_o == 32'd0))
    else $error("data on a failed item");
`endif

endmodule

// ===== tb/ring_fifo_with_overwrite_unit_test.sv =====
// Self-checking testbench for ring_fifo_with_overwrite_unit: directed and random
// write/overwrite/peek/read traffic checked against an in-bench FIFO predictor.
// Depends on rfo_pkg and the ring_fifo_with_overwrite_unit RTL.
module ring_fifo_with_overwrite_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfo_pkg::*;

  // Expected response for one accepted request.
  typedef struct packed {
    logic  success;
    logic  evicted;
    elem_t data;
    cnt_t  fill;
  } fifo_resp_t;

  // Generous cycle budget for the slowest legal run.
  localparam int unsigned CycleLimit = 200_000;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int unsigned HoldCycles = 80;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Request channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OpPeek;
  logic [31:0] data_in = '0;

  // Response channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        success;
  logic        evicted;
  logic [31:0] data_out;
  logic [4:0]  fill_count;

  ring_fifo_with_overwrite_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .data_in_i    (data_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .success_o    (success),
    .evicted_o    (evicted),
    .data_out_o   (data_out),
    .fill_count_o (fill_count)
  );

  // Predictor state: a plain copy of the ring, head and occupancy.
  elem_t fifo_slots [Depth];
  addr_t fifo_head  = '0;
  cnt_t  fifo_count = '0;

  // Responses predicted at request accept, oldest first.
  fifo_resp_t pending_resps [$];

  // Idle percentages for the sender and the receiver, set per phase.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  // Long-stall requests: the test bumps hold_reqs, the receiver serves them.
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  fifo_resp_t  exp_resp;

  // Apply one request to the predicted FIFO and return its response.
  function automatic fifo_resp_t predict_fifo_resp(op_e op, elem_t val);
    fifo_resp_t r;
    r = '0;
    case (op)
      OpWrite, OpOverwrite: begin
        if (fifo_count < Depth) begin
          // room left: append at the tail, count grows
          fifo_slots[addr_t'(fifo_head + fifo_count)] = val;
          fifo_count = fifo_count + 1'b1;
          r.success = 1'b1;
        end else if (op == OpOverwrite) begin
          // full: the oldest slot is returned and reused as the new tail
          r.evicted = 1'b1;
          r.data = fifo_slots[fifo_head];
          fifo_slots[fifo_head] = val;
          fifo_head = fifo_head + 1'b1;
        end
        // plain write on a full FIFO: nothing changes, flags and data stay zero
      end
      default: begin
        if (fifo_count != 0) begin
          r.success = 1'b1;
          r.data = fifo_slots[fifo_head];
          if (op == OpRead) begin
            fifo_head = fifo_head + 1'b1;
            fifo_count = fifo_count - 1'b1;
          end
        end
      end
    endcase
    r.fill = fifo_count;
    return r;
  endfunction

  // Offer one request and hold it until accepted. Entered and left in the
  // time step of a rising edge, so back-to-back items keep valid high.
  task automatic send_request(op_e op, elem_t val);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    data_in  <= val;
    do @(posedge clk); while (!in_ready);
    pending_resps.push_back(predict_fifo_resp(op, val));
  endtask

  // Stop offering and wait until every predicted response has come back.
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each accepted response, then picks next cycle's ready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_resps.size() == 0) begin
          mismatch_count++;
          $error("response with no request outstanding");
        end else begin
          exp_resp = pending_resps.pop_front();
          if (success !== exp_resp.success || evicted !== exp_resp.evicted ||
              data_out !== exp_resp.data || fill_count !== exp_resp.fill) begin
            mismatch_count++;
            if (success !== exp_resp.success)
              $error("success: expected %0d, got %0d", exp_resp.success, success);
            if (evicted !== exp_resp.evicted)
              $error("evicted: expected %0d, got %0d", exp_resp.evicted, evicted);
            if (data_out !== exp_resp.data)
              $error("data_out: expected %08h, got %08h", exp_resp.data, data_out);
            if (fill_count !== exp_resp.fill)
              $error("fill_count: expected %0d, got %0d", exp_resp.fill, fill_count);
          end
        end
      end
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ring_fifo_with_overwrite_unit: mismatch");
      $finish;
    end
  end

  // Peek and read straight after reset: nothing to return.
  task automatic test_empty_access();
    send_request(OpPeek, 32'hFFFF_FFFF);
    send_request(OpRead, 32'h0000_0000);
  endtask

  // Fill with plain writes, then one more write that must be refused.
  task automatic test_fill_until_full();
    send_request(OpWrite, 32'h0000_0000);
    send_request(OpWrite, 32'hFFFF_FFFF);
    send_request(OpWrite, 32'h5555_5555);
    send_request(OpWrite, 32'hAAAA_AAAA);
    repeat (Depth - 4) send_request(OpWrite, $urandom);
    send_request(OpWrite, 32'hDEAD_BEEF);
  endtask

  // Overwrite on a full FIFO evicts the head; with room it behaves as write.
  task automatic test_overwrite_oldest();
    send_request(OpOverwrite, 32'hFFFF_FFFF);
    send_request(OpOverwrite, 32'h0000_0000);
    send_request(OpPeek, $urandom);
    send_request(OpRead, $urandom);
    send_request(OpOverwrite, 32'h8000_0001);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register stays full and input backs up.
  task automatic test_backpressure(int unsigned n_items);
    src_idle_pct = 0;
    hold_reqs++;
    repeat (n_items) send_request(op_e'($urandom_range(3)), $urandom);
    drain_responses();
  endtask

  // Bursts that lean toward filling, toward draining, or neither, so the
  // occupancy sweeps between empty and full (and overwrite) many times.
  task automatic test_random_traffic(int unsigned n_items, int unsigned src_pct,
                                     int unsigned sink_pct);
    int unsigned sent;
    int unsigned bias;
    int unsigned roll;
    op_e         op;
    elem_t       val;
    sent = 0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < n_items) begin
      bias = $urandom_range(2);
      repeat ($urandom_range(1, 24)) begin
        roll = $urandom_range(9);
        if (bias == 2)
          op = op_e'($urandom_range(3));
        else if ((bias == 0) == (roll < 8))
          op = op_e'($urandom_range(1));      // write or overwrite
        else
          op = op_e'($urandom_range(3, 2));   // peek or read
        case ($urandom_range(7))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        send_request(op, val);
        sent++;
      end
    end
    drain_responses();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct  = 35;
    sink_idle_pct = 68;
    test_empty_access();
    test_fill_until_full();
    test_overwrite_oldest();
    drain_responses();

    test_random_traffic(240, 35, 68);
    test_random_traffic(240, 68, 35);
    test_backpressure(40);
    test_random_traffic(240, 0, 0);

    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("ring_fifo_with_overwrite_unit: match");
    else
      $display("ring_fifo_with_overwrite_unit: mismatch");
    $finish;
  end

endmodule
